// ===== hdl/tla_pkg.sv =====
// Shared types and constants of the texture level-of-detail and texel address unit.
// Used by texture_lod_and_texel_address and by its port checker tla_check.
`timescale 1ns / 1ps
`default_nettype none

package tla_pkg;

	localparam int LOD_FRACTION_BITS = 7;
	localparam int LOG2_FRAC_BITS    = 8;
	localparam int LOG2_OFFSET       = 34 * 256;
	localparam int HALF_TEXEL        = 32768;
	localparam int MIP_W             = 4;
	localparam int TEXEL_W           = 12;
	localparam int WEIGHT_W          = 17;
	localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 17'h10000;

	typedef enum logic [2:0] {
		REG_WIDTH_LOG2   = 3'd0,
		REG_HEIGHT_LOG2  = 3'd1,
		REG_WRAP_MODES   = 3'd2,
		REG_FILTER_MODES = 3'd3,
		REG_LOD_BIAS     = 3'd4,
		REG_LOD_MIN      = 3'd5,
		REG_LOD_MAX      = 3'd6
	} tla_reg_t;

	typedef enum logic [1:0] {
		MIP_OFF        = 2'd0,
		MIP_NEAREST    = 2'd1,
		MIP_LINEAR     = 2'd2,
		MIP_LINEAR_ALT = 2'd3
	} tla_mip_t;

	typedef struct packed {
		logic signed [31:0] u_bottom_left;
		logic signed [31:0] v_bottom_left;
		logic signed [31:0] u_bottom_right;
		logic signed [31:0] v_bottom_right;
		logic signed [31:0] u_top_left;
		logic signed [31:0] v_top_left;
		logic signed [31:0] u_top_right;
		logic signed [31:0] v_top_right;
	} tla_in_t;

	typedef struct packed {
		logic [1:0]          corner;
		logic [MIP_W-1:0]    mip_level;
		logic [TEXEL_W-1:0]  texel_x;
		logic [TEXEL_W-1:0]  texel_y;
		logic [WEIGHT_W-1:0] weight;
		logic                last;
	} tla_out_t;

endpackage

`default_nettype wire

// ===== hdl/texture_lod_and_texel_address.sv =====
// Texture address unit: quad level of detail, mip selection and texel fetch requests.
// Depends on tla_pkg for payload structs, register codes and constants.
//
// Usage:
//   Input channel (in_valid/in_ready/in_data) takes one 2x2 quad of Q15.16
//   coordinates per transfer. Output channel (out_valid/out_ready/out_data)
//   gives the fetch requests of each quad in order: corner, then level, then
//   texel SW, SE, NW, NE; last marks the final fetch of a quad.
//   Configuration channel (cfg_valid/cfg_ready/cfg_index/cfg_data) is always
//   ready; write it only while no quad is in flight.
//   Pipeline: 16 level-of-detail stages, then the emitter register, then three
//   fetch stages.
//   Throughput: one fetch per cycle while the receiver is ready. A quad gives
//   4 * levels * texels fetches: 4 (nearest, one level) up to 32 (bilinear,
//   two levels). The emitter walking the fetches of one quad sets the sustained
//   rate; the front pipeline takes a new quad every cycle until it fills.
//   Reset clears all valid bits and loads the register defaults.
//   A stalled receiver holds the output register and the stall backs up
//   stage by stage; nothing is dropped or repeated.
`timescale 1ns / 1ps
`default_nettype none

module texture_lod_and_texel_address
	import tla_pkg::*;
#(
	parameter int MAX_SIZE_LOG2 = 12
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire tla_in_t    in_data,
	output logic            out_valid,
	input  wire logic       out_ready,
	output tla_out_t        out_data,
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic [2:0] cfg_index,
	input  wire logic [11:0] cfg_data
);

	localparam int SQ_W  = 66;
	localparam int LEN_W = SQ_W + 2 * MAX_SIZE_LOG2 + 1;
	localparam int P_W   = $clog2(LEN_W);
	localparam int T_W   = P_W + 10;
	localparam int SZ_W  = $clog2(MAX_SIZE_LOG2 + 1);
	localparam int POS_W = 33 + MAX_SIZE_LOG2;
	localparam int IX_W  = POS_W - 15;
	localparam int NST   = 16;

	typedef struct packed {
		tla_in_t             crd;
		logic [MIP_W-1:0]    lv0;
		logic [MIP_W-1:0]    lv1;
		logic [WEIGHT_W-1:0] mw0;
		logic [WEIGHT_W-1:0] mw1;
		logic                two;
		logic                linear;
	} quad_t;

	// configuration
	logic [3:0]         width_log2_q;
	logic [3:0]         height_log2_q;
	logic [1:0]         wrap_modes_q;
	logic [3:0]         filter_modes_q;
	logic signed [11:0] lod_bias_q;
	logic signed [11:0] lod_min_q;
	logic signed [11:0] lod_max_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_log2_q   <= 4'd8;
			height_log2_q  <= 4'd8;
			wrap_modes_q   <= '0;
			filter_modes_q <= '0;
			lod_bias_q     <= '0;
			lod_min_q      <= '0;
			lod_max_q      <= 12'sd1536;
		end else if (cfg_valid && cfg_ready) begin
			unique case (tla_reg_t'(cfg_index))
				REG_WIDTH_LOG2:   width_log2_q   <= cfg_data[3:0];
				REG_HEIGHT_LOG2:  height_log2_q  <= cfg_data[3:0];
				REG_WRAP_MODES:   wrap_modes_q   <= cfg_data[1:0];
				REG_FILTER_MODES: filter_modes_q <= cfg_data[3:0];
				REG_LOD_BIAS:     lod_bias_q     <= $signed(cfg_data);
				REG_LOD_MIN:      lod_min_q      <= $signed(cfg_data);
				REG_LOD_MAX:      lod_max_q      <= $signed(cfg_data);
				default: ;
			endcase
		end
	end

	logic [SZ_W-1:0] wl, hl, lastl;
	assign wl = (width_log2_q > 4'(MAX_SIZE_LOG2)) ? SZ_W'(MAX_SIZE_LOG2) : SZ_W'(width_log2_q);
	assign hl = (height_log2_q > 4'(MAX_SIZE_LOG2)) ? SZ_W'(MAX_SIZE_LOG2) : SZ_W'(height_log2_q);
	assign lastl = (wl > hl) ? wl : hl;

	// front pipeline control
	logic [NST:1] vld_sn;
	logic [NST:1] en_sn;
	logic [NST:0] vin;
	logic         load;

	assign vin = {vld_sn, in_valid};
	assign en_sn[NST] = !vld_sn[NST] || load;
	for (genvar k = 1; k < NST; k++) begin : g_en
		assign en_sn[k] = !vld_sn[k] || en_sn[k+1];
	end
	assign in_ready = en_sn[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sn <= '0;
		end else begin
			for (int k = 1; k <= NST; k++) begin
				if (en_sn[k]) begin
					vld_sn[k] <= vin[k-1];
				end
			end
		end
	end

	tla_in_t crd_sn [1:NST];

	always_ff @(posedge clk) begin
		if (en_sn[1]) begin
			crd_sn[1] <= in_data;
		end
		for (int k = 2; k <= NST; k++) begin
			if (en_sn[k]) begin
				crd_sn[k] <= crd_sn[k-1];
			end
		end
	end

	// stage 1: quad derivative sums
	logic signed [33:0] d_s1 [4];
	logic signed [33:0] dn [4];

	always_comb begin
		dn[0] = 34'(in_data.u_bottom_right) - 34'(in_data.u_bottom_left)
			+ 34'(in_data.u_top_right) - 34'(in_data.u_top_left);
		dn[1] = 34'(in_data.v_bottom_right) - 34'(in_data.v_bottom_left)
			+ 34'(in_data.v_top_right) - 34'(in_data.v_top_left);
		dn[2] = 34'(in_data.u_top_left) - 34'(in_data.u_bottom_left)
			+ 34'(in_data.u_top_right) - 34'(in_data.u_bottom_right);
		dn[3] = 34'(in_data.v_top_left) - 34'(in_data.v_bottom_left)
			+ 34'(in_data.v_top_right) - 34'(in_data.v_bottom_right);
	end

	always_ff @(posedge clk) begin
		if (en_sn[1]) begin
			d_s1 <= dn;
		end
	end

	// stage 2: squares
	logic [SQ_W-1:0] sq_s2 [4];
	logic [32:0]     ad [4];

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			ad[i] = (d_s1[i] < 0) ? 33'(-d_s1[i]) : 33'(d_s1[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (en_sn[2]) begin
			for (int i = 0; i < 4; i++) begin
				sq_s2[i] <= ad[i] * ad[i];
			end
		end
	end

	// stage 3: squared lengths in base texel space
	logic [LEN_W-1:0] lu_s3, lv_s3;

	always_ff @(posedge clk) begin
		if (en_sn[3]) begin
			lu_s3 <= (LEN_W'(sq_s2[0]) << {wl, 1'b0}) + (LEN_W'(sq_s2[1]) << {hl, 1'b0});
			lv_s3 <= (LEN_W'(sq_s2[2]) << {wl, 1'b0}) + (LEN_W'(sq_s2[3]) << {hl, 1'b0});
		end
	end

	// stage 4: larger length
	logic [LEN_W-1:0] lm_s4;

	always_ff @(posedge clk) begin
		if (en_sn[4]) begin
			lm_s4 <= (lu_s3 < lv_s3) ? lv_s3 : lu_s3;
		end
	end

	// stage 5: leading one
	logic [LEN_W-1:0] lm_s5;
	logic [P_W-1:0]   p_s5, pn;
	logic             zero_s5;

	always_comb begin
		pn = '0;
		for (int i = 0; i < LEN_W; i++) begin
			if (lm_s4[i]) begin
				pn = P_W'(i);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_sn[5]) begin
			lm_s5   <= lm_s4;
			p_s5    <= pn;
			zero_s5 <= (lm_s4 == '0);
		end
	end

	// stage 6: normalize mantissa to Q30
	logic [30:0]      m_s6;
	logic [P_W-1:0]   p_s6;
	logic             zero_s6;
	logic [LEN_W-1:0] nrm;

	always_comb begin
		if (p_s5 >= P_W'(30)) begin
			nrm = lm_s5 >> (p_s5 - P_W'(30));
		end else begin
			nrm = lm_s5 << (P_W'(30) - p_s5);
		end
	end

	always_ff @(posedge clk) begin
		if (en_sn[6]) begin
			m_s6    <= nrm[30:0];
			p_s6    <= p_s5;
			zero_s6 <= zero_s5;
		end
	end

	// stages 7 to 14: one fraction bit of log2 per squaring
	logic [30:0]               m_sq    [7:14];
	logic [LOG2_FRAC_BITS-1:0] frac_sq [7:14];
	logic [P_W-1:0]            p_sq    [7:14];
	logic                      zero_sq [7:14];

	for (genvar g = 7; g <= 14; g++) begin : g_sq
		logic [30:0]               m_in, m_new;
		logic [LOG2_FRAC_BITS-1:0] f_in, f_new;
		logic [P_W-1:0]            p_in;
		logic                      z_in;
		logic [61:0]               prod;

		if (g == 7) begin : g_first
			assign m_in = m_s6;
			assign f_in = '0;
			assign p_in = p_s6;
			assign z_in = zero_s6;
		end else begin : g_next
			assign m_in = m_sq[g-1];
			assign f_in = frac_sq[g-1];
			assign p_in = p_sq[g-1];
			assign z_in = zero_sq[g-1];
		end

		assign prod = m_in * m_in;

		always_comb begin
			if (prod[61]) begin
				m_new = prod[61:31];
				f_new = f_in | (LOG2_FRAC_BITS'(1) << (14 - g));
			end else begin
				m_new = prod[60:30];
				f_new = f_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en_sn[g]) begin
				m_sq[g]    <= m_new;
				frac_sq[g] <= f_new;
				p_sq[g]    <= p_in;
				zero_sq[g] <= z_in;
			end
		end
	end

	// stage 15: level of detail, bias and clamp
	logic signed [11:0]    lod_s15;
	logic signed [T_W-1:0] tp2, lodr, lodc, lmin, lmax;

	always_comb begin
		lmin = T_W'(lod_min_q);
		lmax = T_W'(lod_max_q);
		tp2  = $signed(T_W'({p_sq[14], frac_sq[14]})) - T_W'(LOG2_OFFSET - 2);
		lodr = (tp2 >>> 2) + T_W'(lod_bias_q);
		if (zero_sq[14]) begin
			lodc = lmin;
		end else if (lodr < lmin) begin
			lodc = lmin;
		end else begin
			lodc = lodr;
		end
		if (lodc > lmax) begin
			lodc = lmax;
		end
	end

	always_ff @(posedge clk) begin
		if (en_sn[15]) begin
			lod_s15 <= 12'(lodc);
		end
	end

	// stage 16: filter and level selection
	quad_t      rec_s16, recn;
	logic [12:0] lr;
	logic [4:0]  lnear;
	logic [3:0]  base;
	logic [6:0]  fr;

	always_comb begin
		recn.crd    = crd_sn[15];
		recn.lv0    = '0;
		recn.lv1    = '0;
		recn.mw0    = WEIGHT_ONE;
		recn.mw1    = '0;
		recn.two    = 1'b0;
		recn.linear = filter_modes_q[0];
		lr    = 13'(unsigned'(lod_s15)) + 13'd64;
		lnear = lr[11:7];
		base  = lod_s15[10:7];
		fr    = lod_s15[6:0];
		if (lod_s15 > 12'sd0) begin
			recn.linear = filter_modes_q[1];
			unique case (tla_mip_t'(filter_modes_q[3:2]))
				MIP_OFF: ;
				MIP_NEAREST: begin
					recn.lv0 = (lnear > 5'(lastl)) ? MIP_W'(lastl) : MIP_W'(lnear);
				end
				MIP_LINEAR, MIP_LINEAR_ALT: begin
					if (fr == '0 || 4'(base) >= 4'(lastl)) begin
						recn.lv0 = (4'(base) > 4'(lastl)) ? MIP_W'(lastl) : MIP_W'(base);
					end else begin
						recn.lv0 = MIP_W'(base);
						recn.lv1 = MIP_W'(base) + MIP_W'(1);
						recn.mw0 = {8'(8'd128 - {1'b0, fr}), 9'b0};
						recn.mw1 = {3'b0, fr, 7'b0} << 2;
						recn.two = 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (en_sn[16]) begin
			rec_s16 <= recn;
		end
	end

	// fetch emitter
	quad_t      rec_q;
	logic       busy_q;
	logic [1:0] corner_q;
	logic       k_q;
	logic [1:0] j_q;
	logic       fin, adv;
	logic       vld_e1, vld_e2, vld_e3;
	logic       en_e1, en_e2, en_e3;

	assign en_e3 = !vld_e3 || out_ready;
	assign en_e2 = !vld_e2 || en_e3;
	assign en_e1 = !vld_e1 || en_e2;
	assign adv   = busy_q && en_e1;
	assign fin   = (corner_q == 2'd3) && (k_q == rec_q.two) && (!rec_q.linear || j_q == 2'd3);
	assign load  = !busy_q || (adv && fin);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			corner_q <= '0;
			k_q      <= 1'b0;
			j_q      <= '0;
		end else if (load) begin
			busy_q   <= vld_sn[NST];
			corner_q <= '0;
			k_q      <= 1'b0;
			j_q      <= '0;
		end else if (adv) begin
			if (rec_q.linear && j_q != 2'd3) begin
				j_q <= j_q + 2'd1;
			end else begin
				j_q <= '0;
				if (!k_q && rec_q.two) begin
					k_q <= 1'b1;
				end else begin
					k_q      <= 1'b0;
					corner_q <= corner_q + 2'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rec_q <= rec_s16;
		end
	end

	// fetch stage 1: texel position and bilinear fractions
	logic signed [31:0]   uc, vc;
	logic [MIP_W-1:0]     lvl;
	logic [WEIGHT_W-1:0]  mwc;
	logic [SZ_W-1:0]      lwc, lhc;
	logic signed [POS_W-1:0] px, py;
	logic signed [IX_W-1:0]  xin, yin;
	logic [WEIGHT_W-1:0]  wxn, wyn;

	always_comb begin
		unique case (corner_q)
			2'd0: begin uc = rec_q.crd.u_bottom_left;  vc = rec_q.crd.v_bottom_left;  end
			2'd1: begin uc = rec_q.crd.u_bottom_right; vc = rec_q.crd.v_bottom_right; end
			2'd2: begin uc = rec_q.crd.u_top_left;     vc = rec_q.crd.v_top_left;     end
			default: begin uc = rec_q.crd.u_top_right; vc = rec_q.crd.v_top_right;    end
		endcase
		lvl = k_q ? rec_q.lv1 : rec_q.lv0;
		mwc = k_q ? rec_q.mw1 : rec_q.mw0;
		lwc = (4'(wl) > lvl) ? SZ_W'(4'(wl) - lvl) : '0;
		lhc = (4'(hl) > lvl) ? SZ_W'(4'(hl) - lvl) : '0;
		px  = POS_W'(uc) <<< lwc;
		py  = POS_W'(vc) <<< lhc;
		if (rec_q.linear) begin
			px = px - POS_W'(HALF_TEXEL);
			py = py - POS_W'(HALF_TEXEL);
		end
		xin = IX_W'($signed(px[POS_W-1:16])) + IX_W'(rec_q.linear && j_q[0]);
		yin = IX_W'($signed(py[POS_W-1:16])) + IX_W'(rec_q.linear && j_q[1]);
		wxn = j_q[0] ? {1'b0, px[15:0]} : WEIGHT_ONE - {1'b0, px[15:0]};
		wyn = j_q[1] ? {1'b0, py[15:0]} : WEIGHT_ONE - {1'b0, py[15:0]};
	end

	logic [1:0]             corner_e1;
	logic [MIP_W-1:0]       lvl_e1;
	logic signed [IX_W-1:0] x_e1, y_e1;
	logic [SZ_W-1:0]        lw_e1, lh_e1;
	logic [WEIGHT_W-1:0]    wx_e1, wy_e1, mw_e1;
	logic                   lin_e1, last_e1;

	always_ff @(posedge clk) begin
		if (en_e1) begin
			corner_e1 <= corner_q;
			lvl_e1    <= lvl;
			x_e1      <= xin;
			y_e1      <= yin;
			lw_e1     <= lwc;
			lh_e1     <= lhc;
			wx_e1     <= wxn;
			wy_e1     <= wyn;
			mw_e1     <= mwc;
			lin_e1    <= rec_q.linear;
			last_e1   <= fin;
		end
	end

	// fetch stage 2: wrap and bilinear weight
	function automatic logic [TEXEL_W-1:0] wrap_coord(input logic signed [IX_W-1:0] i,
			input logic [SZ_W-1:0] lg, input logic clamp);
		logic [IX_W-1:0]    top;
		logic [TEXEL_W-1:0] r;
		top = (IX_W'(1) << lg) - IX_W'(1);
		if (!clamp) begin
			r = TEXEL_W'(i & top);
		end else if (i < 0) begin
			r = '0;
		end else if (i > $signed(top)) begin
			r = TEXEL_W'(top);
		end else begin
			r = TEXEL_W'(i);
		end
		return r;
	endfunction

	logic [1:0]          corner_e2;
	logic [MIP_W-1:0]    lvl_e2;
	logic [TEXEL_W-1:0]  x_e2, y_e2;
	logic [WEIGHT_W-1:0] bw_e2, mw_e2;
	logic                lin_e2, last_e2;
	logic [33:0]         bprod;

	assign bprod = wx_e1 * wy_e1;

	always_ff @(posedge clk) begin
		if (en_e2) begin
			corner_e2 <= corner_e1;
			lvl_e2    <= lvl_e1;
			x_e2      <= wrap_coord(x_e1, lw_e1, wrap_modes_q[0]);
			y_e2      <= wrap_coord(y_e1, lh_e1, wrap_modes_q[1]);
			bw_e2     <= bprod[32:16];
			mw_e2     <= mw_e1;
			lin_e2    <= lin_e1;
			last_e2   <= last_e1;
		end
	end

	// fetch stage 3: level weight, output register
	logic [33:0] wprod;

	assign wprod = bw_e2 * mw_e2;

	always_ff @(posedge clk) begin
		if (en_e3) begin
			out_data.corner    <= corner_e2;
			out_data.mip_level <= lvl_e2;
			out_data.texel_x   <= x_e2;
			out_data.texel_y   <= y_e2;
			out_data.weight    <= lin_e2 ? wprod[32:16] : mw_e2;
			out_data.last      <= last_e2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_e1 <= 1'b0;
			vld_e2 <= 1'b0;
			vld_e3 <= 1'b0;
		end else begin
			if (en_e1) begin
				vld_e1 <= busy_q;
			end
			if (en_e2) begin
				vld_e2 <= vld_e1;
			end
			if (en_e3) begin
				vld_e3 <= vld_e2;
			end
		end
	end

	assign out_valid = vld_e3;

endmodule

`default_nettype wire

// ===== hdl/tla_check.sv =====
// Port checker for texture_lod_and_texel_address, attached by bind.
// Depends on tla_pkg for the result struct.
`timescale 1ns / 1ps
`default_nettype none

module tla_check
	import tla_pkg::*;
(
	input wire logic     clk,
	input wire logic     arst_n,
	input wire logic     out_valid,
	input wire logic     out_ready,
	input wire tla_out_t out_data
);

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("stalled result changed");

	a_last_corner: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.last |-> out_data.corner == 2'd3)
		else $error("last fetch not on corner 3");

	a_weight_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.weight <= WEIGHT_ONE)
		else $error("weight above one");

	a_next_quad: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && out_data.last |=> !out_valid || out_data.corner == 2'd0)
		else $error("new quad does not start at corner 0");

	a_corner_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !out_data.last |=> !out_valid
			|| out_data.corner == $past(out_data.corner)
			|| out_data.corner == $past(out_data.corner) + 2'd1)
		else $error("corner order broken within a quad");

endmodule

bind texture_lod_and_texel_address tla_check u_tla_check (.*);

`default_nettype wire

// ===== verif/tla_scoreboard.sv =====
// Fetch-request scoreboard for texture_lod_and_texel_address: a bit-exact predictor
// of level of detail, mip selection, wrapping and blend weights, plus in-order checking.
// Depends on tla_pkg for the payload structs, register codes and constants.
`timescale 1ns / 1ps

import tla_pkg::*;

class tla_scoreboard;

	localparam int SIZE_LOG2_CAP = 12;

	bit [3:0] width_log2;
	bit [3:0] height_log2;
	bit [1:0] wrap_modes;
	bit [3:0] filter_modes;
	longint   lod_bias;
	longint   lod_min;
	longint   lod_max;

	tla_out_t fetch_q[$];
	int       errors;
	int       mismatches;

	function new();
		width_log2   = 8;
		height_log2  = 8;
		wrap_modes   = 0;
		filter_modes = 0;
		lod_bias     = 0;
		lod_min      = 0;
		lod_max      = 1536;
		errors       = 0;
		mismatches   = 0;
	endfunction

	function void write_reg(logic [2:0] index, logic [11:0] value);
		case (index)
			REG_WIDTH_LOG2:   width_log2   = value[3:0];
			REG_HEIGHT_LOG2:  height_log2  = value[3:0];
			REG_WRAP_MODES:   wrap_modes   = value[1:0];
			REG_FILTER_MODES: filter_modes = value[3:0];
			REG_LOD_BIAS:     lod_bias     = longint'(signed'(value));
			REG_LOD_MIN:      lod_min      = longint'(signed'(value));
			REG_LOD_MAX:      lod_max      = longint'(signed'(value));
			default: ;
		endcase
	endfunction

	function logic [127:0] squared_len(longint sx, longint sy, int wl, int hl);
		logic [127:0] ax;
		logic [127:0] ay;
		ax = (sx < 0) ? -sx : sx;
		ay = (sy < 0) ? -sy : sy;
		ax = (ax * ax) << (2 * wl);
		ay = (ay * ay) << (2 * hl);
		return ax + ay;
	endfunction

	// log2 in Q8, truncated; mantissa squared eight times
	function longint log2_q8(logic [127:0] x);
		int               p;
		longint unsigned  m;
		longint           t;
		p = 0;
		for (int i = 0; i < 128; i++)
			if (x[i]) p = i;
		if (p >= 30) m = 64'(x >> (p - 30));
		else m = 64'(x << (30 - p));
		m &= 64'h7FFF_FFFF;
		t = longint'(p) * 256;
		for (int i = 7; i >= 0; i--) begin
			m = (m * m) >> 30;
			if (m >= 64'h8000_0000) begin
				m >>= 1;
				t += longint'(1) << i;
			end
		end
		return t;
	endfunction

	function longint unsigned wrap_texel(longint i, int lg, bit clamp);
		longint unsigned size;
		size = longint'(1) << lg;
		if (!clamp) return longint'(i) & (size - 1);
		if (i < 0) return 0;
		if (longint'(i) > longint'(size - 1)) return size - 1;
		return i;
	endfunction

	function void push_fetch(int c, int level, longint unsigned x, longint unsigned y,
			longint unsigned w);
		tla_out_t f;
		f.corner    = c[1:0];
		f.mip_level = level[3:0];
		f.texel_x   = x[11:0];
		f.texel_y   = y[11:0];
		f.weight    = w[16:0];
		f.last      = 1'b0;
		fetch_q.push_back(f);
	endfunction

	function void corner_fetches(int c, int level, longint unsigned mw, bit linear,
			longint u, longint v, int wl, int hl);
		int              lw;
		int              lh;
		longint          px;
		longint          py;
		longint unsigned bx;
		longint unsigned by;
		longint          ix;
		longint          iy;
		longint unsigned fx;
		longint unsigned fy;
		longint unsigned gx;
		longint unsigned gy;
		lw = (wl > level) ? wl - level : 0;
		lh = (hl > level) ? hl - level : 0;
		px = u * (longint'(1) << lw);
		py = v * (longint'(1) << lh);
		if (linear) begin
			px -= HALF_TEXEL;
			py -= HALF_TEXEL;
		end
		bx = px + (longint'(1) << 47);
		by = py + (longint'(1) << 47);
		ix = longint'(bx >> 16) - (longint'(1) << 31);
		iy = longint'(by >> 16) - (longint'(1) << 31);
		if (!linear) begin
			push_fetch(c, level, wrap_texel(ix, lw, wrap_modes[0]),
				wrap_texel(iy, lh, wrap_modes[1]), mw);
			return;
		end
		fx = bx & 64'hFFFF;
		fy = by & 64'hFFFF;
		gx = 65536 - fx;
		gy = 65536 - fy;
		push_fetch(c, level, wrap_texel(ix, lw, wrap_modes[0]),
			wrap_texel(iy, lh, wrap_modes[1]), (((gx * gy) >> 16) * mw) >> 16);
		push_fetch(c, level, wrap_texel(ix + 1, lw, wrap_modes[0]),
			wrap_texel(iy, lh, wrap_modes[1]), (((fx * gy) >> 16) * mw) >> 16);
		push_fetch(c, level, wrap_texel(ix, lw, wrap_modes[0]),
			wrap_texel(iy + 1, lh, wrap_modes[1]), (((gx * fy) >> 16) * mw) >> 16);
		push_fetch(c, level, wrap_texel(ix + 1, lw, wrap_modes[0]),
			wrap_texel(iy + 1, lh, wrap_modes[1]), (((fx * fy) >> 16) * mw) >> 16);
	endfunction

	function void note_quad(tla_in_t q);
		longint          u[4];
		longint          v[4];
		int              wl;
		int              hl;
		int              last_level;
		int              lv[2];
		longint unsigned mw[2];
		int              nlv;
		int              base;
		longint unsigned frac;
		bit              linear;
		longint          lod;
		longint          t;
		logic [127:0]    lu;
		logic [127:0]    lvq;
		logic [127:0]    lm;
		tla_mip_t        mode;
		tla_out_t        f;
		u[0] = q.u_bottom_left;  v[0] = q.v_bottom_left;
		u[1] = q.u_bottom_right; v[1] = q.v_bottom_right;
		u[2] = q.u_top_left;     v[2] = q.v_top_left;
		u[3] = q.u_top_right;    v[3] = q.v_top_right;
		wl = (width_log2 > SIZE_LOG2_CAP) ? SIZE_LOG2_CAP : width_log2;
		hl = (height_log2 > SIZE_LOG2_CAP) ? SIZE_LOG2_CAP : height_log2;
		last_level = (wl > hl) ? wl : hl;
		lu = squared_len(u[1] - u[0] + u[3] - u[2], v[1] - v[0] + v[3] - v[2], wl, hl);
		lvq = squared_len(u[2] - u[0] + u[3] - u[1], v[2] - v[0] + v[3] - v[1], wl, hl);
		lm = (lu < lvq) ? lvq : lu;
		if (lm == 0) begin
			lod = lod_min;
		end else begin
			t = log2_q8(lm) - LOG2_OFFSET;
			lod = (t + 2 + 65536) / 4 - 16384 + lod_bias;
			if (lod < lod_min) lod = lod_min;
		end
		if (lod > lod_max) lod = lod_max;

		lv[0] = 0; mw[0] = 65536; lv[1] = 0; mw[1] = 0; nlv = 1;
		if (lod < 1) begin
			linear = filter_modes[0];
		end else begin
			linear = filter_modes[1];
			mode = tla_mip_t'(filter_modes[3:2]);
			if (mode == MIP_NEAREST) begin
				base = int'((lod + 64) >>> LOD_FRACTION_BITS);
				lv[0] = (base > last_level) ? last_level : base;
			end else if (mode == MIP_LINEAR || mode == MIP_LINEAR_ALT) begin
				base = int'(lod >>> LOD_FRACTION_BITS);
				frac = lod & 127;
				if (frac == 0 || base >= last_level) begin
					lv[0] = (base > last_level) ? last_level : base;
				end else begin
					lv[0] = base;     mw[0] = (128 - frac) << 9;
					lv[1] = base + 1; mw[1] = frac << 9;
					nlv = 2;
				end
			end
		end
		for (int c = 0; c < 4; c++)
			for (int k = 0; k < nlv; k++)
				corner_fetches(c, lv[k], mw[k], linear, u[c], v[c], wl, hl);
		f = fetch_q.pop_back();
		f.last = 1'b1;
		fetch_q.push_back(f);
	endfunction

	function void check_fetch(tla_out_t got);
		tla_out_t want;
		if (fetch_q.size() == 0) begin
			errors++;
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected fetch %p", got);
			return;
		end
		want = fetch_q.pop_front();
		if (got.corner !== want.corner || got.mip_level !== want.mip_level ||
				got.texel_x !== want.texel_x || got.texel_y !== want.texel_y ||
				got.weight !== want.weight || got.last !== want.last) begin
			errors++;
			mismatches++;
			if (mismatches <= 10)
				$display("fetch mismatch: expected %p got %p", want, got);
		end
	endfunction

endclass

// ===== verif/tb.sv =====
// Testbench top for texture_lod_and_texel_address: drives quads and register writes
// over valid/ready channels with random bursts and stalls, checks fetches in order.
// Depends on tla_pkg and the tla_scoreboard class.
`timescale 1ns / 1ps

module tb;
	import tla_pkg::*;

	localparam logic [2:0] REG_UNUSED = 3'd7;
	localparam int CYCLE_LIMIT = 400000;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	tla_in_t    in_data;
	logic       out_valid;
	logic       out_ready;
	tla_out_t   out_data;
	logic       cfg_valid;
	logic       cfg_ready;
	logic [2:0] cfg_index;
	logic [11:0] cfg_data;

	tla_scoreboard sb;
	int  cycles;
	bit  hold_req;
	bit  hold_done;
	int  hold_left;
	int  ready_style;
	int  style_age;
	int  burst_left;

	texture_lod_and_texel_address u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: done, errors");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_fetch(out_data);
	end

	// receiver: own stall pattern, plus a long hold-off on request
	always @(negedge clk) begin
		if (hold_req && !hold_done) begin
			hold_left = 400;
			hold_done = 1'b1;
		end
		style_age++;
		if (style_age >= 50) begin
			style_age = 0;
			ready_style = $urandom_range(0, 3);
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			case (ready_style)
				0: out_ready <= 1'b1;
				1: out_ready <= $urandom_range(0, 1);
				2: out_ready <= ($urandom_range(0, 7) != 0);
				default: out_ready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	task automatic send_quad(tla_in_t q);
		@(negedge clk);
		in_valid <= 1'b1;
		in_data <= q;
		do @(posedge clk); while (!in_ready);
		sb.note_quad(q);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			int gap;
			gap = $urandom_range(0, 6);
			burst_left = $urandom_range(0, 8);
			if (gap > 0) begin
				@(negedge clk);
				in_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
	endtask

	task automatic write_reg(logic [2:0] index, logic [11:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(index, value);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_regs(int w, int h, int wrap, int filt, int bias, int lo, int hi);
		write_reg(REG_WIDTH_LOG2, 12'(w));
		write_reg(REG_HEIGHT_LOG2, 12'(h));
		write_reg(REG_WRAP_MODES, 12'(wrap));
		write_reg(REG_FILTER_MODES, 12'(filt));
		write_reg(REG_LOD_BIAS, 12'(bias));
		write_reg(REG_LOD_MIN, 12'(lo));
		write_reg(REG_LOD_MAX, 12'(hi));
	endtask

	// drop valid and wait until every expected fetch has come out
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.fetch_q.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	function automatic tla_in_t make_quad(int u0, int v0, int dux, int dvx, int duy,
			int dvy);
		tla_in_t q;
		q.u_bottom_left  = u0;             q.v_bottom_left  = v0;
		q.u_bottom_right = u0 + dux;       q.v_bottom_right = v0 + dvx;
		q.u_top_left     = u0 + duy;       q.v_top_left     = v0 + dvy;
		q.u_top_right    = u0 + dux + duy; q.v_top_right    = v0 + dvx + dvy;
		return q;
	endfunction

	function automatic int rand_step();
		return int'($urandom) >>> $urandom_range(6, 30);
	endfunction

	function automatic tla_in_t random_quad();
		tla_in_t q;
		if ($urandom_range(0, 4) == 0) begin
			q = {$urandom, $urandom, $urandom, $urandom,
				$urandom, $urandom, $urandom, $urandom};
		end else begin
			q = make_quad(int'($urandom) >>> $urandom_range(0, 14),
				int'($urandom) >>> $urandom_range(0, 14),
				rand_step(), rand_step(), rand_step(), rand_step());
			if ($urandom_range(0, 5) == 0)
				q.u_top_right = q.u_top_right ^ int'($urandom_range(0, 255));
		end
		return q;
	endfunction

	task automatic directed_quads();
		send_quad(make_quad(0, 0, 0, 0, 0, 0));
		send_quad(make_quad(32'sh1234_5678, -32'sh0001_2345, 0, 0, 0, 0));
		send_quad({8{32'sh7FFF_FFFF}});
		send_quad({8{32'sh8000_0000}});
		send_quad(make_quad(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1, -1, 0));
		send_quad(make_quad(0, 0, 32'sh0001_0000, 0, 0, 32'sh0001_0000));
		send_quad(make_quad(-32'sh0001_2345, -32'sh0000_8000, 32'sh100, 0, 0, 32'sh100));
		send_quad(make_quad(32'sh8000, 32'sh8000, 32'sh40, 0, 0, 32'sh40));
		send_quad(make_quad(-32'sh0003_0000, 32'sh0002_8000, 32'sh3000, 32'sh500, 0,
			32'sh1800));
		send_quad(make_quad(32'sh7FF0_0000, -32'sh7FF0_0000, 32'sh6A0, 0, 0, 32'sh2D0));
		send_quad(make_quad(32'shFFFF, 32'sh1_0000, 32'sh1, 32'sh1, 0, 0));
		send_quad(make_quad(-1, -32'sh8000, 32'sh0010_0000, 0, 0, 32'sh0010_0000));
	endtask

	task automatic random_phase(int count);
		repeat (count) send_quad(random_quad());
		drain();
	endtask

	initial begin
		sb = new();
		hold_req = 1'b0;
		burst_left = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		directed_quads();
		random_phase(8);

		set_regs(8, 8, 0, 11, 0, 0, 1536);
		write_reg(REG_UNUSED, 12'hFFF);
		directed_quads();
		drain();

		set_regs(12, 3, 3, 5, 2047, -2048, 2047);
		hold_req = 1'b1;
		random_phase(24);

		set_regs(0, 0, 1, 14, -2048, -2048, -2048);
		random_phase(10);

		set_regs(15, 15, 2, 9, 300, 500, 200);
		random_phase(12);

		set_regs(5, 10, 0, 15, -700, -300, 900);
		random_phase(14);

		repeat (2) begin
			set_regs($urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 3),
				$urandom_range(0, 15), int'($urandom_range(0, 1200)) - 600,
				int'($urandom_range(0, 400)) - 300, $urandom_range(0, 1600));
			random_phase(12);
		end

		if (sb.fetch_q.size() != 0)
			sb.errors++;
		if (sb.errors == 0) begin
			$display("tb: done, clean");
		end else begin
			$display("tb: done, errors");
		end
		$finish;
	end

endmodule
